>>> rtl/hex_length_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex length frame receiver
// Concurrent assertion helpers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef HEX_LENGTH_FRAME_RECEIVER_MACROS_SVH
`define HEX_LENGTH_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
`define HLFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hlfr assertion failed");
`define HLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    `HLFR_ASSERT(label, clk, rst_n, (ante) |=> (cons))
`else
`define HLFR_ASSERT(label, clk, rst_n, prop)
`define HLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/hlfr_pkg.sv
// ----------------------------------------------------------------------------
// hlfr_pkg
// Shared types, codes and helpers of the hex length frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

    localparam logic [7:0]  SYNC_FIRST_RESET  = 8'd12;
    localparam logic [7:0]  SYNC_SECOND_RESET = 8'd10;
    localparam logic [15:0] LEN_OVERHEAD      = 16'd5;
    localparam logic [15:0] SIZE_CHARS        = 16'd5;
    localparam logic [15:0] LEN_DIGITS        = 16'd4;
    localparam logic [15:0] CHECK_CHARS       = 16'd4;

    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NAK  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload;
        logic       last_payload;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_result;

    typedef struct packed {
        logic       wr_en;
        logic       index;
        logic [7:0] data;
    } t_cfg_wr;

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = (c < 8'd58) ? (c - 8'd48) : (c - 8'd55);
            return v[3:0];
        end
    endfunction

endpackage

>>> rtl/hex_length_frame_receiver.sv
// ----------------------------------------------------------------------------
// hex_length_frame_receiver
// Byte stream frame receiver with hex length and checksum, stream interface.
// ----------------------------------------------------------------------------
// Received bytes enter on the s_axis channel, one byte per beat in tdata.
// Results leave on the m_axis channel: tuser carries the kind (payload byte,
// ack or nak), tdata the payload byte and tlast the final payload byte of a
// frame. Header, size and checksum bytes produce no beat; the end byte of a
// frame produces the ack or nak beat.
// The sync bytes are set through the write port: index 0 is the first sync
// byte, index 1 the second. Write them only while the block is idle.
// A byte accepted at one edge is held in the input register, passes the
// frame parser and is registered in the output buffer before it is visible
// on m_axis. One byte is accepted every cycle while s_axis_tready is high;
// the parser state update is a single compare, add and shift per byte.
// When m_axis stalls, a skid stage absorbs one more result; after that,
// s_axis_tready drops whenever the held byte would produce a further result,
// until a beat leaves on m_axis. s_axis_tready does not depend
// combinationally on m_axis_tready.
// Reset (synchronous, active low) empties both registers, returns the parser
// to the first header byte and restores the sync bytes to 12 and 10.
// ----------------------------------------------------------------------------
module hex_length_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last_payload
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    hlfr_pkg::t_result w_res;
    hlfr_pkg::t_cfg_wr w_cfg;
    hlfr_pkg::t_item   w_out_item;
    logic              w_space;
    logic              w_adv;

    assign w_cfg.wr_en = i_cfg_wr_en;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_wr_data;

    assign w_adv         = r_in_valid && (!w_res.valid || w_space);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    hlfr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    hlfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv && w_res.valid),
        .i_item  (w_res.item),
        .o_space (w_space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_item  (w_out_item)
    );

    assign m_axis_tdata = w_out_item.payload;
    assign m_axis_tuser = w_out_item.kind;
    assign m_axis_tlast = w_out_item.last_payload;

endmodule

>>> rtl/hlfr_frame.sv
// ----------------------------------------------------------------------------
// hlfr_frame
// Frame parser: header pair check, size and checksum decode, running sum.
// ----------------------------------------------------------------------------
module hlfr_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlfr_pkg::t_cfg_wr i_cfg,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output hlfr_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        PH_HDR1  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_SIZE  = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4,
        PH_END   = 3'd5
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sync_first, r_sync_second;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_len, n_len;
    logic [23:0] r_sum, n_sum;
    logic [15:0] r_check, n_check;

    logic [16:0] w_pos_inc;
    logic [15:0] w_count;
    logic [23:0] w_sum_add;

    assign w_pos_inc = {1'b0, r_pos} + 17'd1;
    assign w_count   = r_len - hlfr_pkg::LEN_OVERHEAD;
    assign w_sum_add = r_sum + {16'd0, i_byte};

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_pos   = r_pos;
        n_len   = r_len;
        n_sum   = r_sum;
        n_check = r_check;
        o_res   = '0;
        case (r_phase)
            PH_HDR2: begin
                if (r_held == r_sync_first && i_byte == r_sync_second) begin
                    n_sum   = {16'd0, r_held} + {16'd0, i_byte};
                    n_pos   = '0;
                    n_len   = '0;
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_SIZE: begin
                n_sum = w_sum_add;
                if (r_pos < hlfr_pkg::LEN_DIGITS) begin
                    n_len = {r_len[11:0], hlfr_pkg::hex_digit(i_byte)};
                end
                n_pos = w_pos_inc[15:0];
                if (w_pos_inc >= {1'b0, hlfr_pkg::SIZE_CHARS}) begin
                    n_pos   = '0;
                    n_check = '0;
                    if (n_len < hlfr_pkg::LEN_OVERHEAD) begin
                        n_phase = PH_HDR1;
                    end else if (n_len == hlfr_pkg::LEN_OVERHEAD) begin
                        n_phase = PH_CHECK;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_sum                    = w_sum_add;
                o_res.valid              = 1'b1;
                o_res.item.kind          = hlfr_pkg::KIND_DATA;
                o_res.item.payload       = i_byte;
                o_res.item.last_payload  = (w_pos_inc >= {1'b0, w_count});
                if (o_res.item.last_payload) begin
                    n_pos   = '0;
                    n_check = '0;
                    n_phase = PH_CHECK;
                end else begin
                    n_pos = w_pos_inc[15:0];
                end
            end
            PH_CHECK: begin
                n_check = {r_check[11:0], hlfr_pkg::hex_digit(i_byte)};
                n_pos   = w_pos_inc[15:0];
                if (w_pos_inc >= {1'b0, hlfr_pkg::CHECK_CHARS}) begin
                    n_pos   = '0;
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_res.valid     = 1'b1;
                o_res.item.kind = (r_sum == {8'd0, r_check}) ? hlfr_pkg::KIND_ACK
                                                             : hlfr_pkg::KIND_NAK;
                n_sum   = '0;
                n_pos   = '0;
                n_phase = PH_HDR1;
            end
            default: begin
                n_held  = i_byte;
                n_phase = PH_HDR2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR1;
            r_held        <= '0;
            r_pos         <= '0;
            r_len         <= '0;
            r_sum         <= '0;
            r_check       <= '0;
            r_sync_first  <= hlfr_pkg::SYNC_FIRST_RESET;
            r_sync_second <= hlfr_pkg::SYNC_SECOND_RESET;
        end else begin
            if (i_step) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_pos   <= n_pos;
                r_len   <= n_len;
                r_sum   <= n_sum;
                r_check <= n_check;
            end
            if (i_cfg.wr_en) begin
                if (i_cfg.index == hlfr_pkg::CFG_SYNC_FIRST) begin
                    r_sync_first <= i_cfg.data;
                end else begin
                    r_sync_second <= i_cfg.data;
                end
            end
        end
    end

endmodule

>>> rtl/hlfr_out_buf.sv
// ----------------------------------------------------------------------------
// hlfr_out_buf
// Result register with a skid stage so the parser keeps running on a stall.
// ----------------------------------------------------------------------------
`include "hex_length_frame_receiver_macros.svh"

module hlfr_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hlfr_pkg::t_item i_item,
    output logic            o_space,
    output logic            o_valid,
    input  logic            i_ready,
    output hlfr_pkg::t_item o_item
);

    logic            r_main_valid, r_skid_valid;
    hlfr_pkg::t_item r_main, r_skid;
    logic            w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_main_valid || (w_pop && !r_skid_valid)) begin
                r_main_valid <= 1'b1;
                r_main       <= i_item;
            end else if (w_pop) begin
                r_main <= r_skid;
                r_skid <= i_item;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_item;
            end
        end else if (w_pop) begin
            r_main_valid <= r_skid_valid;
            r_main       <= r_skid;
            r_skid_valid <= 1'b0;
        end
    end

    `HLFR_ASSERT(a_skid_needs_main, i_clk, i_rst_n, !r_skid_valid || r_main_valid)
    `HLFR_ASSERT(a_push_has_space, i_clk, i_rst_n, !i_push || !r_skid_valid)
    `HLFR_ASSERT_NEXT(a_skid_refills_main, i_clk, i_rst_n, w_pop && r_skid_valid, r_main_valid)

endmodule
